/* rtl/core/bkr_pkg.sv */
`default_nettype none
package bkr_pkg;

  localparam int SLOTS_DEF     = 64;
  localparam int NODE_BITS_DEF = 32;
  localparam int FIELD_W       = 32;
  localparam int ECNT_W        = 7;
  localparam int NCNT_W        = 8;
  localparam int SS_W          = 7;
  localparam int CFG_IDX_W     = 1;
  localparam int ACT_W         = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_TIME   = 1'd1;

  localparam logic [SS_W-1:0]    SAMPLE_SIZE_RST = 7'd64;
  localparam logic [FIELD_W-1:0] STOP_TIME_RST   = 32'hFFFF_FFFF;

  typedef enum logic [ACT_W-1:0] {
    ACT_STOPPED  = 3'd0,
    ACT_DUP      = 3'd1,
    ACT_INSERTED = 3'd2,
    ACT_REPLACED = 3'd3,
    ACT_REJECTED = 3'd4,
    ACT_DUMP     = 3'd5,
    ACT_EMPTY    = 3'd6
  } action_t;

  // Operand of one node table pass
  typedef enum logic [1:0] {
    NSEL_OLD_LO = 2'd0,
    NSEL_OLD_HI = 2'd1,
    NSEL_NEW_LO = 2'd2,
    NSEL_NEW_HI = 2'd3
  } nsel_t;

  typedef struct packed {
    logic    load_in;
    logic    set_frozen;
    logic    eclr;
    logic    eread;
    logic    eskip;
    logic    ewrite;
    logic    ewr_ins;
    logic    nclr;
    logic    nscan;
    logic    nfin;
    nsel_t   nsel;
    logic    emit;
    action_t act;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_dump;
    logic in_stop;
    logic dump_empty;
    logic eidx_end;
    logic dcur_valid;
    logic dlast;
    logic escan_done;
    logic dup;
    logic can_insert;
    logic can_replace;
    logic nscan_done;
    logic old_self;
    logic new_self;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

/* rtl/core/bkr_dp.sv */
`default_nettype none
module bkr_dp #(
  parameter int SLOTS     = bkr_pkg::SLOTS_DEF,
  parameter int NODE_BITS = bkr_pkg::NODE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire bkr_pkg::ctrl_cmd_t              ctl,
  output bkr_pkg::dp_stat_t                    st,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bkr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bkr_pkg::FIELD_W-1:0]     cfg_data,
  input  wire logic                            cmd,
  input  wire logic [bkr_pkg::FIELD_W-1:0]     time_req,
  input  wire logic [bkr_pkg::FIELD_W-1:0]     node_a,
  input  wire logic [bkr_pkg::FIELD_W-1:0]     node_b,
  input  wire logic [bkr_pkg::FIELD_W-1:0]     hash,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [bkr_pkg::ACT_W-1:0]            action,
  output logic [bkr_pkg::FIELD_W-1:0]          out_low,
  output logic [bkr_pkg::FIELD_W-1:0]          out_high,
  output logic [bkr_pkg::FIELD_W-1:0]          out_hash,
  output logic [bkr_pkg::ECNT_W-1:0]           edge_count,
  output logic [bkr_pkg::NCNT_W-1:0]           node_count,
  output logic                                 last
);

  localparam int NW     = (NODE_BITS < bkr_pkg::FIELD_W) ? NODE_BITS : bkr_pkg::FIELD_W;
  localparam int AW     = $clog2(SLOTS);
  localparam int CW     = $clog2(SLOTS + 1);
  localparam int NSLOTS = 2 * SLOTS;
  localparam int NAW    = $clog2(NSLOTS);
  localparam int NCW    = $clog2(NSLOTS + 1);
  localparam int HW     = bkr_pkg::FIELD_W;

  // configuration and freeze
  logic [bkr_pkg::SS_W-1:0] sample_size;
  logic [HW-1:0]            stop_time;
  logic                     frozen;

  // captured item
  logic [NW-1:0] key_lo, key_hi, in_lo, in_hi, in_a, in_b;
  logic [HW-1:0] key_hash;

  // edge store
  logic [NW-1:0] elo_mem  [SLOTS];
  logic [NW-1:0] ehi_mem  [SLOTS];
  logic [HW-1:0] ehash_mem[SLOTS];
  logic [SLOTS-1:0] evalid;
  logic [CW-1:0]    held_e;

  logic [CW-1:0] eidx;
  logic          eidx_end, e_go, erd_vld;
  logic [AW-1:0] erd_idx;
  logic [NW-1:0] erd_lo, erd_hi;
  logic [HW-1:0] erd_hash;

  logic          dup, max_found, free_found;
  logic [AW-1:0] max_slot, free_slot, ewaddr;
  logic [NW-1:0] max_lo, max_hi;
  logic [HW-1:0] max_hash;

  // node table
  logic [NW-1:0] nid_mem  [NSLOTS];
  logic [CW-1:0] nref_mem [NSLOTS];
  logic [NSLOTS-1:0] nvalid;
  logic [NCW-1:0]    held_n;

  logic [NCW-1:0] nidx;
  logic           n_end, n_go, nrd_vld;
  logic [NAW-1:0] nrd_idx;
  logic [NW-1:0]  nrd_id;
  logic [CW-1:0]  nrd_refs;
  logic           nmatched, nfree_found;
  logic [NAW-1:0] nfree;

  logic           nadd, n_hit, n_fin_wr, n_we;
  logic [NW-1:0]  nkey;
  logic [NAW-1:0] n_waddr;
  logic [CW-1:0]  n_wrefs;

  logic [bkr_pkg::SS_W-1:0] cap;
  logic [SLOTS-1:0]         above;

  assign cfg_ready = 1'b1;

  assign in_a  = node_a[NW-1:0];
  assign in_b  = node_b[NW-1:0];
  assign in_lo = (in_a < in_b) ? in_a : in_b;
  assign in_hi = (in_a < in_b) ? in_b : in_a;

  always_comb begin
    if (sample_size == '0) begin
      cap = bkr_pkg::SS_W'(1);
    end else if (sample_size > bkr_pkg::SS_W'(SLOTS)) begin
      cap = bkr_pkg::SS_W'(SLOTS);
    end else begin
      cap = sample_size;
    end
  end

  assign eidx_end = (eidx == CW'(SLOTS));
  assign e_go     = ctl.eread && !eidx_end;
  assign ewaddr   = ctl.ewr_ins ? free_slot : max_slot;
  assign above    = (evalid >> erd_idx) >> 1;

  always_comb begin
    unique case (ctl.nsel)
      bkr_pkg::NSEL_OLD_LO: nkey = max_lo;
      bkr_pkg::NSEL_OLD_HI: nkey = max_hi;
      bkr_pkg::NSEL_NEW_LO: nkey = key_lo;
      bkr_pkg::NSEL_NEW_HI: nkey = key_hi;
      default:              nkey = key_lo;
    endcase
  end

  assign nadd     = (ctl.nsel == bkr_pkg::NSEL_NEW_LO) || (ctl.nsel == bkr_pkg::NSEL_NEW_HI);
  assign n_end    = (nidx == NCW'(NSLOTS));
  assign n_go     = ctl.nscan && !n_end;
  assign n_hit    = nrd_vld && nvalid[nrd_idx] && (nrd_id == nkey);
  assign n_fin_wr = ctl.nfin && nadd && !nmatched && nfree_found;
  assign n_we     = n_hit || n_fin_wr;
  assign n_waddr  = n_hit ? nrd_idx : nfree;
  assign n_wrefs  = !n_hit ? CW'(1) : (nadd ? nrd_refs + CW'(1) : nrd_refs - CW'(1));

  always_comb begin
    st.in_dump     = cmd;
    st.in_stop     = frozen || (time_req > stop_time);
    st.dump_empty  = (evalid == '0);
    st.eidx_end    = eidx_end;
    st.dcur_valid  = !eidx_end && evalid[eidx[AW-1:0]];
    st.dlast       = (above == '0);
    st.escan_done  = eidx_end && !erd_vld;
    st.dup         = dup;
    st.can_insert  = free_found && (bkr_pkg::SS_W'(held_e) < cap);
    st.can_replace = max_found && (key_hash < max_hash);
    st.nscan_done  = n_end && !nrd_vld;
    st.old_self    = (max_lo == max_hi);
    st.new_self    = (key_lo == key_hi);
    st.out_free    = !out_valid || out_ready;
  end

  // config, freeze, item capture
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_size <= bkr_pkg::SAMPLE_SIZE_RST;
      stop_time   <= bkr_pkg::STOP_TIME_RST;
      frozen      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          bkr_pkg::CFG_SAMPLE_SIZE: sample_size <= cfg_data[bkr_pkg::SS_W-1:0];
          bkr_pkg::CFG_STOP_TIME:   stop_time   <= cfg_data;
          default:                  stop_time   <= stop_time;
        endcase
      end
      if (ctl.set_frozen) begin
        frozen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      key_lo   <= in_lo;
      key_hi   <= in_hi;
      key_hash <= hash;
    end
  end

  // edge memory
  always_ff @(posedge clk) begin
    if (ctl.ewrite) begin
      elo_mem[ewaddr]   <= key_lo;
      ehi_mem[ewaddr]   <= key_hi;
      ehash_mem[ewaddr] <= key_hash;
    end
    if (e_go) begin
      erd_lo   <= elo_mem[eidx[AW-1:0]];
      erd_hi   <= ehi_mem[eidx[AW-1:0]];
      erd_hash <= ehash_mem[eidx[AW-1:0]];
      erd_idx  <= eidx[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      evalid  <= '0;
      held_e  <= '0;
      erd_vld <= 1'b0;
    end else begin
      erd_vld <= e_go;
      if (ctl.ewrite) begin
        evalid[ewaddr] <= 1'b1;
        if (ctl.ewr_ins) begin
          held_e <= held_e + CW'(1);
        end
      end
    end
  end

  // edge scan trackers
  always_ff @(posedge clk) begin
    if (rst || ctl.eclr) begin
      eidx       <= '0;
      dup        <= 1'b0;
      max_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (e_go || (ctl.eskip && !eidx_end)) begin
        eidx <= eidx + CW'(1);
      end
      if (erd_vld) begin
        if (evalid[erd_idx]) begin
          if (erd_lo == key_lo && erd_hi == key_hi) begin
            dup <= 1'b1;
          end
          if (!max_found || erd_hash > max_hash) begin
            max_found <= 1'b1;
            max_slot  <= erd_idx;
            max_lo    <= erd_lo;
            max_hi    <= erd_hi;
            max_hash  <= erd_hash;
          end
        end else if (!free_found) begin
          free_found <= 1'b1;
          free_slot  <= erd_idx;
        end
      end
    end
  end

  // node memory
  always_ff @(posedge clk) begin
    if (n_we) begin
      nid_mem[n_waddr]  <= nkey;
      nref_mem[n_waddr] <= n_wrefs;
    end
    if (n_go) begin
      nrd_id   <= nid_mem[nidx[NAW-1:0]];
      nrd_refs <= nref_mem[nidx[NAW-1:0]];
      nrd_idx  <= nidx[NAW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nvalid  <= '0;
      held_n  <= '0;
      nrd_vld <= 1'b0;
    end else begin
      nrd_vld <= n_go;
      if (n_hit && !nadd && nrd_refs == CW'(1)) begin
        nvalid[nrd_idx] <= 1'b0;
        held_n          <= held_n - NCW'(1);
      end
      if (n_fin_wr) begin
        nvalid[nfree] <= 1'b1;
        held_n        <= held_n + NCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.nclr) begin
      nidx        <= '0;
      nmatched    <= 1'b0;
      nfree_found <= 1'b0;
    end else begin
      if (n_go) begin
        nidx <= nidx + NCW'(1);
      end
      if (n_hit) begin
        nmatched <= 1'b1;
      end
      if (nrd_vld && !nvalid[nrd_idx] && !nfree_found) begin
        nfree_found <= 1'b1;
        nfree       <= nrd_idx;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      action     <= ctl.act;
      edge_count <= bkr_pkg::ECNT_W'(held_e);
      node_count <= bkr_pkg::NCNT_W'(held_n);
      last       <= (ctl.act == bkr_pkg::ACT_DUMP) ? (above == '0) : 1'b1;
      priority if (ctl.act == bkr_pkg::ACT_REPLACED) begin
        out_low  <= HW'(max_lo);
        out_high <= HW'(max_hi);
        out_hash <= max_hash;
      end else if (ctl.act == bkr_pkg::ACT_DUMP) begin
        out_low  <= HW'(erd_lo);
        out_high <= HW'(erd_hi);
        out_hash <= erd_hash;
      end else begin
        out_low  <= '0;
        out_high <= '0;
        out_hash <= '0;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/bkr_ctrl.sv */
`default_nettype none
module bkr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire bkr_pkg::dp_stat_t  st,
  output bkr_pkg::ctrl_cmd_t      ctl
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_ESCAN  = 8'b0000_0010,
    S_DECIDE = 8'b0000_0100,
    S_NSCAN  = 8'b0000_1000,
    S_NFIN   = 8'b0001_0000,
    S_EMIT   = 8'b0010_0000,
    S_DRD    = 8'b0100_0000,
    S_DWT    = 8'b1000_0000
  } state_t;

  state_t           state, state_next;
  bkr_pkg::action_t act, act_next;
  bkr_pkg::nsel_t   nsel, nsel_next;
  logic             accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      act   <= bkr_pkg::ACT_STOPPED;
      nsel  <= bkr_pkg::NSEL_NEW_LO;
    end else begin
      state <= state_next;
      act   <= act_next;
      nsel  <= nsel_next;
    end
  end

  always_comb begin
    state_next = state;
    act_next   = act;
    nsel_next  = nsel;
    ctl        = '0;
    ctl.nsel   = nsel;
    ctl.act    = act;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          ctl.load_in = 1'b1;
          ctl.eclr    = 1'b1;
          priority if (st.in_dump) begin
            act_next   = st.dump_empty ? bkr_pkg::ACT_EMPTY : bkr_pkg::ACT_DUMP;
            state_next = st.dump_empty ? S_EMIT : S_DRD;
          end else if (st.in_stop) begin
            ctl.set_frozen = 1'b1;
            act_next       = bkr_pkg::ACT_STOPPED;
            state_next     = S_EMIT;
          end else begin
            state_next = S_ESCAN;
          end
        end
      end
      S_ESCAN: begin
        ctl.eread = 1'b1;
        if (st.escan_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (st.dup) begin
          act_next   = bkr_pkg::ACT_DUP;
          state_next = S_EMIT;
        end else if (st.can_insert) begin
          ctl.ewrite  = 1'b1;
          ctl.ewr_ins = 1'b1;
          ctl.nclr    = 1'b1;
          act_next    = bkr_pkg::ACT_INSERTED;
          nsel_next   = bkr_pkg::NSEL_NEW_LO;
          state_next  = S_NSCAN;
        end else if (st.can_replace) begin
          ctl.ewrite = 1'b1;
          ctl.nclr   = 1'b1;
          act_next   = bkr_pkg::ACT_REPLACED;
          nsel_next  = bkr_pkg::NSEL_OLD_LO;
          state_next = S_NSCAN;
        end else begin
          act_next   = bkr_pkg::ACT_REJECTED;
          state_next = S_EMIT;
        end
      end
      S_NSCAN: begin
        ctl.nscan = 1'b1;
        if (st.nscan_done) begin
          state_next = S_NFIN;
        end
      end
      S_NFIN: begin
        ctl.nfin = 1'b1;
        ctl.nclr = 1'b1;
        unique case (nsel)
          bkr_pkg::NSEL_OLD_LO: begin
            nsel_next  = st.old_self ? bkr_pkg::NSEL_NEW_LO : bkr_pkg::NSEL_OLD_HI;
            state_next = S_NSCAN;
          end
          bkr_pkg::NSEL_OLD_HI: begin
            nsel_next  = bkr_pkg::NSEL_NEW_LO;
            state_next = S_NSCAN;
          end
          bkr_pkg::NSEL_NEW_LO: begin
            nsel_next  = bkr_pkg::NSEL_NEW_HI;
            state_next = st.new_self ? S_EMIT : S_NSCAN;
          end
          bkr_pkg::NSEL_NEW_HI: begin
            state_next = S_EMIT;
          end
          default: state_next = S_EMIT;
        endcase
      end
      S_EMIT: begin
        if (st.out_free) begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DRD: begin
        priority if (st.eidx_end) begin
          state_next = S_IDLE;
        end else if (st.dcur_valid) begin
          ctl.eread  = 1'b1;
          state_next = S_DWT;
        end else begin
          ctl.eskip = 1'b1;
        end
      end
      S_DWT: begin
        if (st.out_free) begin
          ctl.emit   = 1'b1;
          state_next = st.dlast ? S_IDLE : S_DRD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/bottom_k_edge_reservoir_sampler_core.sv */
// Bottom-k edge reservoir sampler.
// Input channel (in_valid/in_ready): one beat is an edge arrival (cmd 0:
// time_req, node_a, node_b, hash) or a dump request (cmd 1).
// Output channel (out_valid/out_ready): one beat per result; an arrival
// gives exactly one beat, a dump one beat per held edge in slot order (or
// one "empty" beat), with last set on the final beat of the item.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 sample_size,
// index 1 stop_time; write only while the block is idle.
// Sequence: an arrival scans all SLOTS edge slots, decides, then runs one
// pass over the 2*SLOTS node table per endpoint touched before the result
// is registered: no pass for a duplicate or reject, up to four passes for
// a replace. A frozen arrival goes straight to the result. A dump skips
// each empty slot and reads each held edge in turn. One item is in flight
// at a time; in_ready is high only when the controller is idle.
// Reset: reservoir and node table empty, not frozen, sample_size 64,
// stop_time all ones. No clearing pass is needed.
// A stalled receiver holds the result in the output register; the block
// waits with its next result until that beat is taken.
`default_nettype none
module bottom_k_edge_reservoir_sampler_core #(
  parameter int SLOTS     = bkr_pkg::SLOTS_DEF,
  parameter int NODE_BITS = bkr_pkg::NODE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bkr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bkr_pkg::FIELD_W-1:0]   cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          cmd,
  input  wire logic [bkr_pkg::FIELD_W-1:0]   time_req,
  input  wire logic [bkr_pkg::FIELD_W-1:0]   node_a,
  input  wire logic [bkr_pkg::FIELD_W-1:0]   node_b,
  input  wire logic [bkr_pkg::FIELD_W-1:0]   hash,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [bkr_pkg::ACT_W-1:0]          action,
  output logic [bkr_pkg::FIELD_W-1:0]        out_low,
  output logic [bkr_pkg::FIELD_W-1:0]        out_high,
  output logic [bkr_pkg::FIELD_W-1:0]        out_hash,
  output logic [bkr_pkg::ECNT_W-1:0]         edge_count,
  output logic [bkr_pkg::NCNT_W-1:0]         node_count,
  output logic                               last
);

  bkr_pkg::ctrl_cmd_t ctl;
  bkr_pkg::dp_stat_t  st;

  // sequence the scans and node passes
  bkr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .ctl      (ctl)
  );

  // hold the reservoir, node table, config and output register
  bkr_dp #(
    .SLOTS     (SLOTS),
    .NODE_BITS (NODE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .st         (st),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .time_req   (time_req),
    .node_a     (node_a),
    .node_b     (node_b),
    .hash       (hash),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .action     (action),
    .out_low    (out_low),
    .out_high   (out_high),
    .out_hash   (out_hash),
    .edge_count (edge_count),
    .node_count (node_count),
    .last       (last)
  );

  // the reported edge count never exceeds the slot count
  a_edge_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (edge_count <= bkr_pkg::ECNT_W'(SLOTS)))
    else $error("edge count above slot count");

  // every held node is an endpoint of a held edge
  a_node_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, node_count} <= {edge_count, 1'b0} + 9'd0))
    else $error("node count above twice the edge count");

  // an accepted item leaves the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after an accepted beat");

  // only dump entries may be non-final
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && action != bkr_pkg::ACT_DUMP) |-> last)
    else $error("non-dump result without last");

endmodule
`default_nettype wire

/* sim/bkr_checker.sv */
`default_nettype none
module bkr_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  input  wire logic                          cfg_ready,
  input  wire logic [bkr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bkr_pkg::FIELD_W-1:0]   cfg_data,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic                          cmd,
  input  wire logic [bkr_pkg::FIELD_W-1:0]   time_req,
  input  wire logic [bkr_pkg::FIELD_W-1:0]   node_a,
  input  wire logic [bkr_pkg::FIELD_W-1:0]   node_b,
  input  wire logic [bkr_pkg::FIELD_W-1:0]   hash,
  input  wire logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire logic [bkr_pkg::ACT_W-1:0]     action,
  input  wire logic [bkr_pkg::FIELD_W-1:0]   out_low,
  input  wire logic [bkr_pkg::FIELD_W-1:0]   out_high,
  input  wire logic [bkr_pkg::FIELD_W-1:0]   out_hash,
  input  wire logic [bkr_pkg::ECNT_W-1:0]    edge_count,
  input  wire logic [bkr_pkg::NCNT_W-1:0]    node_count,
  input  wire logic                          last,
  output int                                 pending,
  output int                                 fails,
  output int                                 beats_seen
);

  localparam int NSLOT = bkr_pkg::SLOTS_DEF;
  localparam int NNODE = 2 * bkr_pkg::SLOTS_DEF;

  typedef struct packed {
    bkr_pkg::action_t            act;
    logic [bkr_pkg::FIELD_W-1:0] lo;
    logic [bkr_pkg::FIELD_W-1:0] hi;
    logic [bkr_pkg::FIELD_W-1:0] h;
    logic [bkr_pkg::ECNT_W-1:0]  ec;
    logic [bkr_pkg::NCNT_W-1:0]  nc;
    logic                        fin;
  } result_t;

  result_t sample_q[$];

  logic [bkr_pkg::SS_W-1:0]    cap_reg;
  logic [bkr_pkg::FIELD_W-1:0] stop_reg;
  logic [bkr_pkg::FIELD_W-1:0] e_lo [NSLOT];
  logic [bkr_pkg::FIELD_W-1:0] e_hi [NSLOT];
  logic [bkr_pkg::FIELD_W-1:0] e_pri[NSLOT];
  logic                        e_vld[NSLOT];
  logic [bkr_pkg::FIELD_W-1:0] n_id [NNODE];
  int                          n_ref[NNODE];
  logic                        is_frozen;
  int                          n_edges;
  int                          n_nodes;

  assign pending = sample_q.size();

  task automatic report(input string what, input logic [bkr_pkg::FIELD_W-1:0] got,
                        input logic [bkr_pkg::FIELD_W-1:0] want);
    fails++;
    $display("mismatch %s: got %h want %h (beat %0d)", what, got, want, beats_seen);
  endtask

  function automatic void push(bkr_pkg::action_t a, logic [bkr_pkg::FIELD_W-1:0] lo,
                               logic [bkr_pkg::FIELD_W-1:0] hi,
                               logic [bkr_pkg::FIELD_W-1:0] h, logic fin);
    result_t r;
    r.act = a; r.lo = lo; r.hi = hi; r.h = h;
    r.ec = n_edges[bkr_pkg::ECNT_W-1:0]; r.nc = n_nodes[bkr_pkg::NCNT_W-1:0]; r.fin = fin;
    sample_q.insert(sample_q.size(), r);
  endfunction

  function automatic void ref_node(logic [bkr_pkg::FIELD_W-1:0] id, bit add);
    int fs;
    fs = -1;
    for (int i = 0; i < NNODE; i++) begin
      if (n_ref[i] != 0 && n_id[i] == id) begin
        if (add) n_ref[i]++;
        else begin
          n_ref[i]--;
          if (n_ref[i] == 0) n_nodes--;
        end
        return;
      end
      if (n_ref[i] == 0 && fs < 0) fs = i;
    end
    if (add && fs >= 0) begin
      n_id[fs] = id;
      n_ref[fs] = 1;
      n_nodes++;
    end
  endfunction

  function automatic void ref_edge(logic [bkr_pkg::FIELD_W-1:0] lo,
                                   logic [bkr_pkg::FIELD_W-1:0] hi, bit add);
    ref_node(lo, add);
    if (hi != lo) ref_node(hi, add);
  endfunction

  // Expected beats for one accepted item; updates the reservoir copy.
  function automatic void sample_edge(logic c, logic [bkr_pkg::FIELD_W-1:0] t,
                                      logic [bkr_pkg::FIELD_W-1:0] a,
                                      logic [bkr_pkg::FIELD_W-1:0] b,
                                      logic [bkr_pkg::FIELD_W-1:0] h);
    logic [bkr_pkg::FIELD_W-1:0] lo, hi, olo, ohi, oh;
    int free_s, max_s, lastv, cap;
    free_s = -1; max_s = -1; lastv = -1;
    if (c) begin
      for (int i = 0; i < NSLOT; i++) if (e_vld[i]) lastv = i;
      if (lastv < 0) push(bkr_pkg::ACT_EMPTY, '0, '0, '0, 1'b1);
      else
        for (int i = 0; i < NSLOT; i++)
          if (e_vld[i]) push(bkr_pkg::ACT_DUMP, e_lo[i], e_hi[i], e_pri[i], i == lastv);
      return;
    end
    // freeze is sticky until reset
    if (is_frozen || t > stop_reg) begin
      is_frozen = 1'b1;
      push(bkr_pkg::ACT_STOPPED, '0, '0, '0, 1'b1);
      return;
    end
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    for (int i = 0; i < NSLOT; i++) begin
      if (e_vld[i]) begin
        if (e_lo[i] == lo && e_hi[i] == hi) begin
          push(bkr_pkg::ACT_DUP, '0, '0, '0, 1'b1);
          return;
        end
        if (max_s < 0 || e_pri[i] > e_pri[max_s]) max_s = i;
      end else if (free_s < 0) free_s = i;
    end
    cap = cap_reg;
    if (cap < 1) cap = 1;
    if (cap > NSLOT) cap = NSLOT;
    if (n_edges < cap && free_s >= 0) begin
      e_lo[free_s] = lo; e_hi[free_s] = hi; e_pri[free_s] = h; e_vld[free_s] = 1'b1;
      n_edges++;
      ref_edge(lo, hi, 1'b1);
      push(bkr_pkg::ACT_INSERTED, '0, '0, '0, 1'b1);
    end else if (max_s >= 0 && h < e_pri[max_s]) begin
      olo = e_lo[max_s]; ohi = e_hi[max_s]; oh = e_pri[max_s];
      ref_edge(olo, ohi, 1'b0);
      e_lo[max_s] = lo; e_hi[max_s] = hi; e_pri[max_s] = h;
      ref_edge(lo, hi, 1'b1);
      push(bkr_pkg::ACT_REPLACED, olo, ohi, oh, 1'b1);
    end else push(bkr_pkg::ACT_REJECTED, '0, '0, '0, 1'b1);
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      sample_q.delete();
      cap_reg = bkr_pkg::SAMPLE_SIZE_RST;
      stop_reg = bkr_pkg::STOP_TIME_RST;
      for (int i = 0; i < NSLOT; i++) e_vld[i] = 1'b0;
      for (int i = 0; i < NNODE; i++) n_ref[i] = 0;
      is_frozen = 1'b0;
      n_edges = 0;
      n_nodes = 0;
      fails = 0;
      beats_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bkr_pkg::CFG_SAMPLE_SIZE) cap_reg = cfg_data[bkr_pkg::SS_W-1:0];
        else if (cfg_index == bkr_pkg::CFG_STOP_TIME) stop_reg = cfg_data;
      end
      if (in_valid && in_ready) sample_edge(cmd, time_req, node_a, node_b, hash);
      if (out_valid && out_ready) begin
        beats_seen++;
        if (sample_q.size() == 0) report("unexpected beat", {29'd0, action}, '0);
        else begin
          want = sample_q.pop_front();
          if (action != want.act) report("action", {29'd0, action}, {29'd0, want.act});
          if (out_low != want.lo) report("out_low", out_low, want.lo);
          if (out_high != want.hi) report("out_high", out_high, want.hi);
          if (out_hash != want.h) report("out_hash", out_hash, want.h);
          if (edge_count != want.ec) report("edge_count", {25'd0, edge_count}, {25'd0, want.ec});
          if (node_count != want.nc) report("node_count", {24'd0, node_count}, {24'd0, want.nc});
          if (last != want.fin) report("last", {31'd0, last}, {31'd0, want.fin});
        end
      end
    end
  end

endmodule
`default_nettype wire

/* sim/tb_top.sv */
`default_nettype none
module tb_top;

  // Slowest run: ~400 items, each a full arrival or a 64-beat dump with the
  // longest receiver stalls, plus gaps; take that several times.
  localparam int CYCLE_LIMIT = 1500000;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [bkr_pkg::CFG_IDX_W-1:0] cfg_index = bkr_pkg::CFG_SAMPLE_SIZE;
  logic [bkr_pkg::FIELD_W-1:0]   cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          cmd = 1'b0;
  logic [bkr_pkg::FIELD_W-1:0]   time_req = '0;
  logic [bkr_pkg::FIELD_W-1:0]   node_a = '0;
  logic [bkr_pkg::FIELD_W-1:0]   node_b = '0;
  logic [bkr_pkg::FIELD_W-1:0]   hash = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [bkr_pkg::ACT_W-1:0]     action;
  logic [bkr_pkg::FIELD_W-1:0]   out_low, out_high, out_hash;
  logic [bkr_pkg::ECNT_W-1:0]    edge_count;
  logic [bkr_pkg::NCNT_W-1:0]    node_count;
  logic                          last;

  int pending, fails, beats_seen;
  int cycles = 0;
  int items_sent = 0;
  int cfg_writes = 0;
  bit no_idle = 1'b0;   // phase-wide switch: drop all gaps and stalls
  bit took_beat = 1'b0;
  int stall_left = 0;

  logic [bkr_pkg::FIELD_W-1:0] node_pool[24];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  bottom_k_edge_reservoir_sampler_core DUT (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .cmd, .time_req, .node_a, .node_b, .hash,
    .out_valid, .out_ready, .action, .out_low, .out_high, .out_hash,
    .edge_count, .node_count, .last
  );

  bkr_checker u_checker (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .cmd, .time_req, .node_a, .node_b, .hash,
    .out_valid, .out_ready, .action, .out_low, .out_high, .out_hash,
    .edge_count, .node_count, .last,
    .pending, .fails, .beats_seen
  );

  // Hard stop on a hang.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycles, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: after each taken beat, draw a random stall.
  always @(posedge clk) took_beat <= out_valid && out_ready;

  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else begin
      if (took_beat) stall_left = no_idle ? 0 : $urandom_range(0, 7);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Present one item after a random gap; hold it until accepted.
  // All driving happens at the falling edge, so the rising edge sees stable inputs.
  task automatic send_item(input logic c, input logic [bkr_pkg::FIELD_W-1:0] t,
                           input logic [bkr_pkg::FIELD_W-1:0] a,
                           input logic [bkr_pkg::FIELD_W-1:0] b,
                           input logic [bkr_pkg::FIELD_W-1:0] h);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd = c; time_req = t; node_a = a; node_b = b; hash = h;
    in_valid = 1'b1;
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Drain, then write one register while the block is idle.
  task automatic write_reg(input logic [bkr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bkr_pkg::FIELD_W-1:0] val);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_writes++;
  endtask

  task automatic random_phase(input int count);
    logic [bkr_pkg::FIELD_W-1:0] a, b, h, t;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      t = $urandom;
      if (pick < 85) begin
        a = node_pool[$urandom_range(0, 23)];
        b = node_pool[$urandom_range(0, 23)];
      end else begin
        a = $urandom;
        b = $urandom;
      end
      // Half of the hashes come from a few values so ties and evictions of
      // equal priority show up.
      case ($urandom_range(0, 7))
        0: h = 32'h0;
        1: h = 32'hFFFF_FFFF;
        2: h = 32'h8000_0000;
        3: h = {2'($urandom_range(0, 3)), 30'h0};
        default: h = $urandom;
      endcase
      if ($urandom_range(0, 99) < 8) send_item(1'b1, t, a, b, h);
      else send_item(1'b0, t, a, b, h);
    end
  endtask

  initial begin
    logic [bkr_pkg::SS_W-1:0] sizes[7];
    sizes = '{7'd64, 7'd3, 7'd1, 7'd16, 7'd127, 7'd8, 7'd40};
    node_pool[0] = 32'h0;
    node_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 24; i++) node_pool[i] = $urandom;

    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed: empty dump, extremes, endpoint order, duplicate, self loop.
    send_item(1'b1, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(1'b0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    send_item(1'b0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0);
    send_item(1'b0, 32'h1234, 32'h5, 32'h5, 32'h8000_0000);
    send_item(1'b1, 32'h0, 32'h0, 32'h0, 32'h0);
    // Full at two edges: replace the largest, then a tie on the largest
    // rejects an equal hash and a smaller one evicts the lowest tied slot.
    write_reg(bkr_pkg::CFG_SAMPLE_SIZE, 32'd2);
    send_item(1'b0, 32'h10, 32'h9, 32'h7, 32'h8000_0000);
    send_item(1'b0, 32'h11, 32'h1, 32'h2, 32'h8000_0000);
    send_item(1'b0, 32'h12, 32'h2, 32'h1, 32'h7FFF_FFFF);
    send_item(1'b1, 32'h0, 32'h0, 32'h0, 32'h0);
    // Capacity zero acts as one, below what is held: replace only.
    write_reg(bkr_pkg::CFG_SAMPLE_SIZE, 32'd0);
    send_item(1'b0, 32'h13, 32'h3, 32'h4, 32'h0);
    send_item(1'b0, 32'h14, 32'h6, 32'h8, 32'hFFFF_FFFF);
    send_item(1'b1, 32'h0, 32'h0, 32'h0, 32'h0);
    // Capacity above the slot count; stop time zero still passes time zero.
    write_reg(bkr_pkg::CFG_SAMPLE_SIZE, 32'd127);
    write_reg(bkr_pkg::CFG_STOP_TIME, 32'h0);
    send_item(1'b0, 32'h0, 32'hAAAA_5555, 32'h5555_AAAA, 32'h1);
    write_reg(bkr_pkg::CFG_STOP_TIME, 32'hFFFF_FFFF);

    // Random phases over several capacities; every third runs without gaps.
    for (int p = 0; p < 7; p++) begin
      write_reg(bkr_pkg::CFG_SAMPLE_SIZE, {25'd0, sizes[p]});
      no_idle = (p % 3 == 2);
      random_phase(52);
    end
    no_idle = 1'b0;

    // Freeze: equal to stop time passes, later times freeze; dump still works.
    write_reg(bkr_pkg::CFG_STOP_TIME, 32'd1000);
    send_item(1'b0, 32'd1000, 32'h77, 32'h78, 32'h0);
    send_item(1'b0, 32'd1001, 32'h79, 32'h7A, 32'h0);
    send_item(1'b0, 32'd5, 32'h7B, 32'h7C, 32'h0);
    send_item(1'b1, 32'h0, 32'h0, 32'h0, 32'h0);
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);

    $display("run covered %0d items and %0d result beats over %0d register writes",
             items_sent, beats_seen, cfg_writes);
    $display("capacities 0..127, ties, self loops, duplicates, dumps and freeze exercised");
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", fails);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
